FILE: rtl/ltm_pkg.sv
package ltm_pkg;

    // Sync and frame type characters.
    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_T      = 8'h54;
    localparam logic [7:0] TYPE_GPS    = 8'h47;
    localparam logic [7:0] TYPE_ATT    = 8'h41;

    // Frame lengths include the sync pair, the type byte and the checksum.
    localparam int GPS_FRAME_LEN = 18;
    localparam int ATT_FRAME_LEN = 10;
    localparam int FRAME_OVERHEAD = 4;

    localparam logic [3:0] GPS_PAYLOAD_LEN = 4'(GPS_FRAME_LEN - FRAME_OVERHEAD);
    localparam logic [3:0] ATT_PAYLOAD_LEN = 4'(ATT_FRAME_LEN - FRAME_OVERHEAD);
    localparam int         PAYLOAD_DEPTH   = GPS_FRAME_LEN - FRAME_OVERHEAD;

    localparam logic [1:0] FIX_MASK = 2'b11;
    localparam logic [5:0] MIN_SATS_RESET = 6'd5;

    // Codes of the frame_done field.
    localparam logic [1:0] DONE_NONE = 2'd0;
    localparam logic [1:0] DONE_GPS  = 2'd1;
    localparam logic [1:0] DONE_ATT  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GOT_DOLLAR,
        PH_GOT_T,
        PH_PAYLOAD
    } ltm_phase_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  frame_done;
        logic [31:0] latitude;
        logic [31:0] longitude;
        logic [7:0]  ground_speed;
        logic [31:0] altitude;
        logic [5:0]  satellites;
        logic [1:0]  fix_kind;
        logic [15:0] pitch_raw;
        logic [15:0] roll_raw;
        logic [15:0] heading_raw;
        logic [1:0]  status_flags;
    } ltm_result_t;

endpackage

FILE: rtl/ltm_parse_core.sv
module ltm_parse_core
    import ltm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        step,
    input  logic [7:0]  byte_in,
    output ltm_result_t result
);

    ltm_phase_t  phase_reg, phase_next;
    logic        gps_frame_reg, gps_frame_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [5:0]  min_sats_reg;
    logic [31:0] lat_reg, lat_next;
    logic [31:0] lon_reg, lon_next;
    logic [7:0]  speed_reg, speed_next;
    logic [31:0] alt_reg, alt_next;
    logic [7:0]  sats_fix_reg, sats_fix_next;
    logic [15:0] pitch_reg, pitch_next;
    logic [15:0] roll_reg, roll_next;
    logic [15:0] heading_reg, heading_next;
    logic [1:0]  sticky_reg, sticky_next;
    logic [7:0]  payload_store_reg [PAYLOAD_DEPTH];

    logic        store_we;
    logic        accepted;
    logic [1:0]  frame_done;
    logic [3:0]  payload_len;
    logic [31:0] gps_alt;

    assign payload_len = gps_frame_reg ? GPS_PAYLOAD_LEN : ATT_PAYLOAD_LEN;
    assign gps_alt = {payload_store_reg[12], payload_store_reg[11],
                      payload_store_reg[10], payload_store_reg[9]};

    always_comb
    begin
        phase_next     = phase_reg;
        gps_frame_next = gps_frame_reg;
        count_next     = count_reg;
        xor_next       = xor_reg;
        lat_next       = lat_reg;
        lon_next       = lon_reg;
        speed_next     = speed_reg;
        alt_next       = alt_reg;
        sats_fix_next  = sats_fix_reg;
        pitch_next     = pitch_reg;
        roll_next      = roll_reg;
        heading_next   = heading_reg;
        sticky_next    = sticky_reg;
        store_we       = 1'b0;
        accepted       = 1'b1;
        frame_done     = DONE_NONE;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (byte_in == SYNC_DOLLAR)
                    phase_next = PH_GOT_DOLLAR;
            end
            PH_GOT_DOLLAR:
            begin
                // Any other byte keeps the parser waiting for the T.
                if (byte_in == SYNC_T)
                    phase_next = PH_GOT_T;
            end
            PH_GOT_T:
            begin
                if (byte_in == TYPE_GPS || byte_in == TYPE_ATT)
                begin
                    phase_next     = PH_PAYLOAD;
                    gps_frame_next = (byte_in == TYPE_GPS);
                    count_next     = '0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    accepted   = 1'b0;
                end
            end
            PH_PAYLOAD:
            begin
                xor_next = (count_reg == '0) ? byte_in : (xor_reg ^ byte_in);
                if (count_reg >= payload_len)
                begin
                    // This is the checksum byte.
                    phase_next = PH_IDLE;
                    if (xor_next == '0)
                    begin
                        if (gps_frame_reg)
                        begin
                            lat_next = {payload_store_reg[3], payload_store_reg[2],
                                        payload_store_reg[1], payload_store_reg[0]};
                            lon_next = {payload_store_reg[7], payload_store_reg[6],
                                        payload_store_reg[5], payload_store_reg[4]};
                            speed_next    = payload_store_reg[8];
                            alt_next      = gps_alt;
                            sats_fix_next = payload_store_reg[13];
                            if (payload_store_reg[13][7:2] >= min_sats_reg)
                                sticky_next[0] = 1'b1;
                            if ($signed(gps_alt) > 0)
                                sticky_next[1] = 1'b1;
                            frame_done = DONE_GPS;
                        end
                        else
                        begin
                            pitch_next   = {payload_store_reg[1], payload_store_reg[0]};
                            roll_next    = {payload_store_reg[3], payload_store_reg[2]};
                            heading_next = {payload_store_reg[5], payload_store_reg[4]};
                            frame_done   = DONE_ATT;
                        end
                    end
                    else
                    begin
                        accepted = 1'b0;
                    end
                end
                else
                begin
                    store_we   = 1'b1;
                    count_next = count_reg + 4'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.accepted     = accepted;
        result.frame_done   = frame_done;
        result.latitude     = lat_next;
        result.longitude    = lon_next;
        result.ground_speed = speed_next;
        result.altitude     = alt_next;
        result.satellites   = sats_fix_next[7:2];
        result.fix_kind     = sats_fix_next[1:0] & FIX_MASK;
        result.pitch_raw    = pitch_next;
        result.roll_raw     = roll_next;
        result.heading_raw  = heading_next;
        result.status_flags = sticky_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sats_reg <= MIN_SATS_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_sats_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            gps_frame_reg <= 1'b0;
            count_reg     <= '0;
            xor_reg       <= '0;
            lat_reg       <= '0;
            lon_reg       <= '0;
            speed_reg     <= '0;
            alt_reg       <= '0;
            sats_fix_reg  <= '0;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            heading_reg   <= '0;
            sticky_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            gps_frame_reg <= gps_frame_next;
            count_reg     <= count_next;
            xor_reg       <= xor_next;
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
            speed_reg     <= speed_next;
            alt_reg       <= alt_next;
            sats_fix_reg  <= sats_fix_next;
            pitch_reg     <= pitch_next;
            roll_reg      <= roll_next;
            heading_reg   <= heading_next;
            sticky_reg    <= sticky_next;
        end
    end

    // The store is only read for entries written by the current frame.
    always_ff @(posedge clk)
    begin
        if (step && store_we)
            payload_store_reg[count_reg] <= byte_in;
    end

endmodule

FILE: rtl/ltm_telemetry_frame_parser.sv
// The result for an accepted input word is registered in the output register or,
// under a stall, in the skid stage; one result word is produced for every input word.
// Throughput: one word per cycle unless in_stall; the parser state updates per byte.
// Reset (rst_n low, asynchronous): parser idle hunting for the dollar sign, held
// record and sticky flags cleared, satellite threshold set to 5, output empty.
module ltm_telemetry_frame_parser
    import ltm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // Configuration: satellite threshold for the sticky fix flag.
    input  logic               cfg_wr_en,
    input  logic [5:0]         cfg_wr_data,

    // Input channel: one received byte per word.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_in,

    // Output channel: one result word per input word.
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic [1:0]         frame_done,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic [7:0]         ground_speed,
    output logic signed [31:0] altitude,
    output logic [5:0]         satellites,
    output logic [1:0]         fix_kind,
    output logic [15:0]        pitch_raw,
    output logic [15:0]        roll_raw,
    output logic [15:0]        heading_raw,
    output logic [1:0]         status_flags
);

    ltm_result_t result;

    logic        in_fire;
    logic        out_fire;
    logic        out_free;

    logic        out_valid_reg, out_valid_next;
    ltm_result_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    ltm_result_t skid_data_reg, skid_data_next;

    // The skid stage makes the input stall a plain register, so the stall from
    // downstream never reaches the upstream side in the same cycle. The input
    // stalls only while the skid stage holds a word.
    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_fire;

    // The parser core advances its state on every accepted byte and presents
    // the result for that byte combinationally.
    ltm_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (in_fire),
        .byte_in     (byte_in),
        .result      (result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // The older word in the skid stage goes out first.
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                if (in_fire)
                    out_data_next = result;
            end
        end
        else if (in_fire)
        begin
            // Output is held by a stall, so park the new word.
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_data_reg.accepted;
    assign frame_done   = out_data_reg.frame_done;
    assign latitude     = $signed(out_data_reg.latitude);
    assign longitude    = $signed(out_data_reg.longitude);
    assign ground_speed = out_data_reg.ground_speed;
    assign altitude     = $signed(out_data_reg.altitude);
    assign satellites   = out_data_reg.satellites;
    assign fix_kind     = out_data_reg.fix_kind;
    assign pitch_raw    = out_data_reg.pitch_raw;
    assign roll_raw     = out_data_reg.roll_raw;
    assign heading_raw  = out_data_reg.heading_raw;
    assign status_flags = out_data_reg.status_flags;

endmodule
